// File: design/bblc_pkg.sv
// bblc_pkg: shared types and constants for the byte budget LRU cache.
// No dependencies.
package bblc_pkg;

    localparam int DEF_ENTRIES  = 64;
    localparam int DEF_KEY_BITS = 32;

    localparam logic [31:0] BUDGET_RESET = 32'd67108864;
    localparam logic [47:0] CLOCK_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam logic [39:0] BYTES_MAX    = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        K_LOOKUP   = 2'd0,
        K_REQUEST  = 2'd1,
        K_COMPLETE = 2'd2,
        K_PLAY     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_EMPTY       = 2'd0,
        ST_PENDING     = 2'd1,
        ST_DECODED     = 2'd2,
        ST_UNDECODABLE = 2'd3
    } t_slot_st;

    typedef enum logic [2:0] {
        RS_DONE        = 3'd0,
        RS_MISS        = 3'd1,
        RS_KNOWN       = 3'd2,
        RS_FULL        = 3'd3,
        RS_NOT_PENDING = 3'd4
    } t_res_st;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture the incoming request
        logic clr_scan; // reset scan pointer and search results
        logic scan;     // examine one slot
        logic apply;    // commit the found slot / counters
        logic evict;    // evict the oldest found by the last scan
        logic init;     // reset-time clear pass step
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic over_budget;
        logic oldest_found;
        logic init_last;
    } t_sts;

endpackage

// File: design/bblc_datapath.sv
// bblc_datapath: entry table memories, scan pointer, statistics registers.
// Depends on bblc_pkg.
module bblc_datapath
    import bblc_pkg::*;
#(
    parameter int ENTRIES  = DEF_ENTRIES,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [31:0] i_budget,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_key,
    input  logic        i_decoded_ok,
    input  logic [31:0] i_decoded_bytes,
    input  logic        i_from_memory,
    output logic [2:0]  o_status,
    output logic        o_hit,
    output logic [5:0]  o_evicted,
    output logic [6:0]  o_decoded_entries,
    output logic [39:0] o_total_bytes_out,
    output logic [31:0] o_plays_cached,
    output logic [31:0] o_plays_live
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // slot status is in a memory too: cleared by a pass after reset
    logic [1:0]          m_st   [ENTRIES];
    logic [KEY_BITS-1:0] m_key  [ENTRIES];
    logic [47:0]         m_use  [ENTRIES];
    logic [31:0]         m_bytes[ENTRIES];

    t_kind               r_kind;
    logic [KEY_BITS-1:0] r_key;
    logic                r_ok, r_mem;
    logic [31:0]         r_bytes;
    logic [IW-1:0]       r_ptr, r_ptr_d;
    logic                r_rd_v;
    logic [1:0]          r_rd_st;
    logic [KEY_BITS-1:0] r_rd_key;
    logic [47:0]         r_rd_use;
    logic [31:0]         r_rd_bytes;
    logic                r_found, r_empty_f, r_old_f, r_init_last;
    logic [IW-1:0]       r_found_i, r_empty_i, r_old_i, r_keep_i;
    logic [1:0]          r_found_st;
    logic [47:0]         r_old_use;
    logic [31:0]         r_old_bytes;
    logic [47:0]         r_clock;
    logic [39:0]         r_total;
    logic [CW-1:0]       r_dcount;
    logic [31:0]         r_pc, r_pl;
    logic [5:0]          r_evn;
    logic [2:0]          r_status;
    logic                r_hit;
    logic                r_grew;   // current request decoded a new entry
    logic [IW-1:0]       r_init_i;

    logic [47:0] w_tick;
    logic [40:0] w_sum;
    assign w_tick = (r_clock < CLOCK_MAX) ? r_clock + 48'd1 : r_clock;
    assign w_sum  = {1'b0, r_total} + {9'd0, r_bytes};

    // memory reads, registered
    always_ff @(posedge i_clk) begin
        r_rd_st    <= m_st[r_ptr];
        r_rd_key   <= m_key[r_ptr];
        r_rd_use   <= m_use[r_ptr];
        r_rd_bytes <= m_bytes[r_ptr];
        r_ptr_d    <= r_ptr;
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            m_st[r_init_i] <= ST_EMPTY;
        end else if (i_cmd.apply && r_kind == K_REQUEST && !r_found && r_empty_f) begin
            m_st[r_empty_i]  <= ST_PENDING;
            m_key[r_empty_i] <= r_key;
        end else if (i_cmd.apply && r_kind == K_COMPLETE && r_found
                     && r_found_st == ST_PENDING) begin
            if (r_ok) begin
                m_st[r_found_i]    <= ST_DECODED;
                m_bytes[r_found_i] <= r_bytes;
                m_use[r_found_i]   <= w_tick;
            end else begin
                m_st[r_found_i] <= ST_UNDECODABLE;
            end
        end else if (i_cmd.apply && r_kind == K_LOOKUP && r_found
                     && r_found_st == ST_DECODED) begin
            m_use[r_found_i] <= w_tick;
        end else if (i_cmd.evict) begin
            m_st[r_old_i] <= ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock     <= '0;
            r_total     <= '0;
            r_dcount    <= '0;
            r_pc        <= '0;
            r_pl        <= '0;
            r_init_i    <= '0;
            r_init_last <= 1'b0;
            r_ptr       <= '0;
            r_rd_v      <= 1'b0;
            r_grew      <= 1'b0;
        end else begin
            if (i_cmd.init) begin
                r_init_i    <= r_init_i + 1'b1;
                r_init_last <= (r_init_i == IW'(ENTRIES - 1));
            end
            if (i_cmd.load) begin
                r_kind  <= t_kind'(i_kind);
                r_key   <= KEY_BITS'(i_key);
                r_ok    <= i_decoded_ok;
                r_bytes <= i_decoded_bytes;
                r_mem   <= i_from_memory;
                r_evn   <= '0;
                r_hit   <= 1'b0;
                r_grew  <= 1'b0;
            end
            if (i_cmd.clr_scan) begin
                r_ptr     <= '0;
                r_rd_v    <= 1'b0;
                r_found   <= 1'b0;
                r_empty_f <= 1'b0;
                r_old_f   <= 1'b0;
            end
            if (i_cmd.scan) begin
                if (r_ptr != IW'(ENTRIES - 1)) r_ptr <= r_ptr + 1'b1;
                r_rd_v <= 1'b1;
                if (r_rd_v) begin
                    if (r_rd_st != ST_EMPTY && r_rd_key == r_key && !r_found) begin
                        r_found    <= 1'b1;
                        r_found_i  <= r_ptr_d;
                        r_found_st <= r_rd_st;
                    end
                    if (r_rd_st == ST_EMPTY && !r_empty_f) begin
                        r_empty_f <= 1'b1;
                        r_empty_i <= r_ptr_d;
                    end
                    if (r_rd_st == ST_DECODED && r_ptr_d != r_keep_i
                        && (!r_old_f || r_rd_use < r_old_use)) begin
                        r_old_f     <= 1'b1;
                        r_old_i     <= r_ptr_d;
                        r_old_use   <= r_rd_use;
                        r_old_bytes <= r_rd_bytes;
                    end
                end
            end
            if (i_cmd.apply) begin
                r_status <= RS_DONE;
                case (r_kind)
                    K_LOOKUP: begin
                        if (r_found && r_found_st == ST_DECODED) begin
                            r_clock <= w_tick;
                            r_hit   <= 1'b1;
                        end else begin
                            r_status <= RS_MISS;
                        end
                    end
                    K_REQUEST: begin
                        if (r_found)         r_status <= RS_KNOWN;
                        else if (!r_empty_f) r_status <= RS_FULL;
                    end
                    K_COMPLETE: begin
                        if (!r_found || r_found_st != ST_PENDING) begin
                            r_status <= RS_NOT_PENDING;
                        end else if (r_ok) begin
                            r_clock  <= w_tick;
                            r_total  <= w_sum[40] ? BYTES_MAX : w_sum[39:0];
                            r_dcount <= r_dcount + 1'b1;
                            r_grew   <= 1'b1;
                        end
                        r_keep_i <= r_found_i;
                    end
                    default: begin
                        if (r_mem) begin
                            if (r_pc != COUNT_MAX) r_pc <= r_pc + 32'd1;
                        end else begin
                            if (r_pl != COUNT_MAX) r_pl <= r_pl + 32'd1;
                        end
                    end
                endcase
            end
            if (i_cmd.evict) begin
                r_total  <= (r_total > {8'd0, r_old_bytes})
                            ? r_total - {8'd0, r_old_bytes} : '0;
                r_dcount <= r_dcount - 1'b1;
                if (r_evn != 6'd63) r_evn <= r_evn + 6'd1;
            end
        end
    end

    assign o_sts.scan_last    = r_rd_v && (r_ptr_d == IW'(ENTRIES - 1));
    // eviction only follows a successful decode
    assign o_sts.over_budget  = r_grew && (r_total > {8'd0, i_budget})
                                && (r_dcount > CW'(1));
    assign o_sts.oldest_found = r_old_f;
    assign o_sts.init_last    = r_init_last;

    assign o_status          = r_status;
    assign o_hit             = r_hit;
    assign o_evicted         = r_evn;
    assign o_decoded_entries = (r_dcount > CW'(127)) ? 7'd127 : 7'(r_dcount);
    assign o_total_bytes_out = r_total;
    assign o_plays_cached    = r_pc;
    assign o_plays_live      = r_pl;
endmodule

// File: design/bblc_ctrl.sv
// bblc_ctrl: sequencer for clear pass, key scan, commit and eviction scans.
// Depends on bblc_pkg.
module bblc_ctrl
    import bblc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  logic i_kind_complete,
    input  logic i_kind_play,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_SCAN, S_APPLY, S_CHECK, S_ESCAN, S_EVICT, S_OUT
    } t_state;

    t_state r_state;
    logic   r_cplx;

    always_comb begin
        o_cmd          = '0;
        o_cmd.init     = (r_state == S_INIT);
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.clr_scan = ((r_state == S_IDLE) && i_in_valid)
                         || ((r_state == S_CHECK) && r_cplx && i_sts.over_budget);
        o_cmd.scan     = (r_state == S_SCAN) || (r_state == S_ESCAN);
        o_cmd.apply    = (r_state == S_APPLY);
        o_cmd.evict    = (r_state == S_EVICT);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cplx  <= 1'b0;
        end else begin
            case (r_state)
                S_INIT:  if (i_sts.init_last) r_state <= S_IDLE;
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cplx  <= i_kind_complete;
                        r_state <= i_kind_play ? S_APPLY : S_SCAN;
                    end
                end
                S_SCAN:  if (i_sts.scan_last) r_state <= S_APPLY;
                S_APPLY: r_state <= S_CHECK;
                S_CHECK: begin
                    if (r_cplx && i_sts.over_budget) r_state <= S_ESCAN;
                    else                             r_state <= S_OUT;
                end
                S_ESCAN: begin
                    if (i_sts.scan_last)
                        r_state <= i_sts.oldest_found ? S_EVICT : S_OUT;
                end
                S_EVICT: r_state <= S_CHECK;
                S_OUT:   if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_INIT;
            endcase
        end
    end
endmodule

// File: design/byte_budget_lru_cache.sv
// Byte budget LRU cache: one result per request.
// Lookup, request and completion each take one key scan over the table, plus
// one eviction scan per eviction; play counts skip the scan.
// One request at a time; the table walk reads one slot per cycle.
// Reset: synchronous; a clear pass over every slot empties the slot table
// before the first request is taken. Config writes are taken only while idle.
module byte_budget_lru_cache
    import bblc_pkg::*;
#(
    parameter int ENTRIES  = DEF_ENTRIES,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_key,
    input  logic        i_decoded_ok,
    input  logic [31:0] i_decoded_bytes,
    input  logic        i_from_memory,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic        o_hit,
    output logic [5:0]  o_evicted,
    output logic [6:0]  o_decoded_entries,
    output logic [39:0] o_total_bytes_out,
    output logic [31:0] o_plays_cached,
    output logic [31:0] o_plays_live
);
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [31:0] r_budget;

    // budget register: written only while no request is in flight
    assign o_cfg_ready = o_in_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                        r_budget <= BUDGET_RESET;
        else if (i_cfg_valid && o_cfg_ready) r_budget <= i_cfg_data;
    end

    bblc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_kind_complete(i_kind == K_COMPLETE),
        .i_kind_play    (i_kind == K_PLAY),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd)
    );

    bblc_datapath #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_budget         (r_budget),
        .i_kind           (i_kind),
        .i_key            (i_key),
        .i_decoded_ok     (i_decoded_ok),
        .i_decoded_bytes  (i_decoded_bytes),
        .i_from_memory    (i_from_memory),
        .o_status         (o_status),
        .o_hit            (o_hit),
        .o_evicted        (o_evicted),
        .o_decoded_entries(o_decoded_entries),
        .o_total_bytes_out(o_total_bytes_out),
        .o_plays_cached   (o_plays_cached),
        .o_plays_live     (o_plays_live)
    );
endmodule

// File: design/bblc_checker.sv
// bblc_checker: port-level assertions for byte_budget_lru_cache, with bind.
// Depends on the top level's ports only.
module bblc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic        o_hit,
    input logic [5:0]  o_evicted,
    input logic [6:0]  o_decoded_entries
);
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result dropped");
    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> o_status == 3'd0 && o_evicted == 6'd0)
        else $error("hit with bad status");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= 3'd4 && o_decoded_entries <= 7'd64)
        else $error("result out of range");
endmodule

bind byte_budget_lru_cache bblc_checker u_chk (.*);
